// File: rtl/core/dihedral_angle_top_macros.svh
// Assertion macros for the dihedral angle core.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef DIHEDRAL_ANGLE_TOP_MACROS_SVH
`define DIHEDRAL_ANGLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every rising edge outside reset.
`define DANG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dihedral angle core: assertion failed");
// The condition must never be seen at a rising edge outside reset.
`define DANG_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("dihedral angle core: forbidden condition seen");
`else
`define DANG_ASSERT(lbl, clk, rstn, prop)
`define DANG_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/core/dang_pkg.sv
// Shared constants, types and helper functions of the dihedral angle core.
// No dependencies; imported by every module of the core except dang_dly.
package dang_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned COORD_WIDTH_DEF = 18;
  localparam int unsigned ATAN_STEPS_DEF  = 16;

  // Fixed-point formats.
  localparam int unsigned LEN_FRAC  = 16;
  localparam int unsigned NORM_BITS = 30;
  localparam int unsigned ANG_FRAC  = 24;
  localparam int unsigned OUT_FRAC  = 13;
  localparam int unsigned ANG_W     = 28;
  localparam int unsigned TORS_W    = 16;
  localparam int unsigned TAB_LEN   = 24;

  // Width of one partial-product operand in the wide multipliers.
  localparam int unsigned CHUNK_W = 32;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t HALF_PI_Q = 28'sd26353589;
  localparam ang_t PI_Q      = 28'sd52707179;
  localparam logic signed [TORS_W-1:0] OUT_MAX = 16'sd25736;

  // Arctangent of 2^-i in radians scaled by 2^24, rounded.
  function automatic ang_t atan_tab(input int unsigned idx);
    ang_t val;
    case (idx)
      0:       val = 28'sd13176795;
      1:       val = 28'sd7778716;
      2:       val = 28'sd4110060;
      3:       val = 28'sd2086331;
      4:       val = 28'sd1047214;
      5:       val = 28'sd524117;
      6:       val = 28'sd262123;
      7:       val = 28'sd131069;
      8:       val = 28'sd65536;
      9:       val = 28'sd32768;
      10:      val = 28'sd16384;
      11:      val = 28'sd8192;
      12:      val = 28'sd4096;
      13:      val = 28'sd2048;
      14:      val = 28'sd1024;
      15:      val = 28'sd512;
      16:      val = 28'sd256;
      17:      val = 28'sd128;
      18:      val = 28'sd64;
      19:      val = 28'sd32;
      20:      val = 28'sd16;
      21:      val = 28'sd8;
      22:      val = 28'sd4;
      23:      val = 28'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Latency of dang_mul for the given operand widths.
  function automatic int unsigned mul_lat(input int unsigned aw, input int unsigned bw);
    return ((aw + CHUNK_W - 1) / CHUNK_W) * ((bw + CHUNK_W - 1) / CHUNK_W) + 2;
  endfunction

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/core/dang_dly.sv
// Registered delay line used to align operands between the core's pipeline branches.
// Stand-alone; no package needed.
module dang_dly #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  if (DEPTH == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [WIDTH-1:0] stage_q [DEPTH];

    // Shift the line on every clock.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < DEPTH; i++) stage_q[i] <= '0;
      end else begin
        stage_q[0] <= d_i;
        for (int i = 1; i < DEPTH; i++) stage_q[i] <= stage_q[i-1];
      end
    end

    assign q_o = stage_q[DEPTH-1];
  end

endmodule

// File: rtl/core/dang_mul.sv
// Pipelined signed multiplier built from 32 x 32 bit partial products, one per stage.
// Depends on dang_pkg for the chunk width.
module dang_mul import dang_pkg::*; #(
  parameter int unsigned A_WIDTH = 32,
  parameter int unsigned B_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic signed [A_WIDTH-1:0]         a_i,
  input  logic signed [B_WIDTH-1:0]         b_i,
  output logic signed [A_WIDTH+B_WIDTH-1:0] p_o
);

  localparam int unsigned NA    = (A_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned NB    = (B_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned NP    = NA * NB;
  localparam int unsigned AP    = NA * CHUNK_W;
  localparam int unsigned BP    = NB * CHUNK_W;
  localparam int unsigned ACC_W = AP + BP;
  localparam int unsigned P_W   = A_WIDTH + B_WIDTH;

  logic [A_WIDTH-1:0] abs_a;
  logic [B_WIDTH-1:0] abs_b;

  logic [AP-1:0]    ma_q  [NP];
  logic [BP-1:0]    mb_q  [NP];
  logic [ACC_W-1:0] acc_q [NP+1];
  logic             neg_q [NP+1];
  logic signed [P_W-1:0] mag;
  logic signed [P_W-1:0] p_q;

  assign abs_a = a_i[A_WIDTH-1] ? A_WIDTH'(-a_i) : a_i;
  assign abs_b = b_i[B_WIDTH-1] ? B_WIDTH'(-b_i) : b_i;

  // Entry stage: magnitudes and the sign of the product.
  always_ff @(posedge clk_i) begin
    ma_q[0]  <= AP'(abs_a);
    mb_q[0]  <= BP'(abs_b);
    acc_q[0] <= '0;
    neg_q[0] <= a_i[A_WIDTH-1] ^ b_i[B_WIDTH-1];
  end

  // One partial product is added in each stage.
  for (genvar k = 1; k <= NP; k++) begin : g_pp
    localparam int unsigned IA = (k - 1) / NB;
    localparam int unsigned IB = (k - 1) % NB;
    localparam int unsigned SH = (IA + IB) * CHUNK_W;
    logic [2*CHUNK_W-1:0] pp;

    assign pp = ma_q[k-1][IA*CHUNK_W +: CHUNK_W] * mb_q[k-1][IB*CHUNK_W +: CHUNK_W];

    always_ff @(posedge clk_i) begin
      acc_q[k] <= acc_q[k-1] + (ACC_W'(pp) << SH);
      neg_q[k] <= neg_q[k-1];
    end

    if (k < NP) begin : g_pass
      always_ff @(posedge clk_i) begin
        ma_q[k] <= ma_q[k-1];
        mb_q[k] <= mb_q[k-1];
      end
    end
  end

  // Final stage restores the sign.
  assign mag = acc_q[NP][P_W-1:0];

  always_ff @(posedge clk_i) begin
    p_q <= neg_q[NP] ? -mag : mag;
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/dang_sqrt.sv
// Pipelined integer square root of s * 2^(2*FRAC), one result bit per stage.
// Depends on dang_pkg only through the common import.
module dang_sqrt import dang_pkg::*; #(
  parameter int unsigned IN_W = 38,
  parameter int unsigned FRAC = LEN_FRAC
) (
  input  logic                               clk_i,
  input  logic [IN_W-1:0]                    s_i,
  output logic [(IN_W + 2*FRAC + 1)/2 - 1:0] root_o
);

  localparam int unsigned NW = IN_W + 2 * FRAC;
  localparam int unsigned RW = (NW + 1) / 2;

  logic [NW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  // Stage k settles result bit RW-1-k against the running remainder.
  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int unsigned P = RW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [NW:0]   trial;
    logic          fits;

    if (k == 0) begin : g_first
      assign rem_in  = NW'(s_i) << (2 * FRAC);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = ((NW + 1)'(root_in) << (P + 1)) + ((NW + 1)'(1) << (2 * P));
    assign fits  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i) begin
      root_q[k] <= fits ? (root_in | (RW'(1) << P)) : root_in;
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= fits ? (rem_in - trial[NW-1:0]) : rem_in;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// File: rtl/core/dang_cordic.sv
// Normalisation, CORDIC vectoring and output rounding of the dihedral angle core.
// Depends on dang_pkg and on the assertion macros header.
`include "dihedral_angle_top_macros.svh"
module dang_cordic import dang_pkg::*; #(
  parameter int unsigned IN_W  = 96,
  parameter int unsigned STEPS = ATAN_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic signed [IN_W-1:0]   x_i,
  input  logic signed [IN_W-1:0]   y_i,
  output logic                     vld_o,
  output logic signed [TORS_W-1:0] torsion_o
);

  localparam int unsigned NS    = $clog2(IN_W);
  localparam int unsigned ST    = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
  localparam int unsigned CX_W  = NORM_BITS + 3;
  localparam int unsigned SHIFT = ANG_FRAC - OUT_FRAC;
  localparam int unsigned R_W   = ANG_W - SHIFT;
  localparam int unsigned LAT   = NS + ST + 2;
  localparam ang_t        ROUND_Q = ang_t'(1) <<< (SHIFT - 1);

  typedef struct packed {
    logic vld;
    logic xneg;
    logic yneg;
    logic zero;
  } flag_t;

  flag_t            fn_q [NS+1];
  logic [IN_W-1:0]  nx_q [NS+1];
  logic [IN_W-1:0]  ny_q [NS+1];

  flag_t                  fc_q [ST];
  logic signed [CX_W-1:0] cx_q [ST];
  logic signed [CX_W-1:0] cy_q [ST];
  ang_t                   z_q  [ST];

  flag_t       f_in;
  logic [IN_W-1:0] abs_x, abs_y;

  ang_t                     z_c, zr_c;
  logic signed [R_W-1:0]    r_c;
  logic signed [TORS_W-1:0] t_c;
  logic signed [TORS_W-1:0] torsion_q;
  logic                     vld_q;

  // Entry stage: signs, magnitudes and the degenerate case.
  assign abs_x = x_i[IN_W-1] ? IN_W'(-x_i) : x_i;
  assign abs_y = y_i[IN_W-1] ? IN_W'(-y_i) : y_i;

  always_comb begin
    f_in.vld  = vld_i;
    f_in.xneg = x_i[IN_W-1];
    f_in.yneg = y_i[IN_W-1];
    f_in.zero = (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q[0] <= '0;
    end else begin
      fn_q[0] <= f_in;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q[0] <= abs_x;
    ny_q[0] <= abs_y;
  end

  // Normalisation: shift both magnitudes right by descending powers of two
  // while the larger one still keeps at least NORM_BITS significant bits.
  for (genvar n = 0; n < NS; n++) begin : g_norm
    localparam int unsigned SH = 1 << (NS - 1 - n);
    logic [IN_W-1:0] m_or;
    logic            big;

    assign m_or = nx_q[n] | ny_q[n];
    assign big  = |(m_or >> (SH + NORM_BITS - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fn_q[n+1] <= '0;
      end else begin
        fn_q[n+1] <= fn_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      nx_q[n+1] <= big ? (nx_q[n] >> SH) : nx_q[n];
      ny_q[n+1] <= big ? (ny_q[n] >> SH) : ny_q[n];
    end
  end

  // CORDIC vectoring, one micro-rotation per stage.
  for (genvar i = 0; i < ST; i++) begin : g_rot
    logic signed [CX_W-1:0] cx_in, cy_in, dx, dy;
    ang_t                   z_in;
    flag_t                  fl_in;

    if (i == 0) begin : g_first
      assign cx_in = CX_W'(nx_q[NS][NORM_BITS-1:0]);
      assign cy_in = CX_W'(ny_q[NS][NORM_BITS-1:0]);
      assign z_in  = '0;
      assign fl_in = fn_q[NS];
    end else begin : g_next
      assign cx_in = cx_q[i-1];
      assign cy_in = cy_q[i-1];
      assign z_in  = z_q[i-1];
      assign fl_in = fc_q[i-1];
    end

    assign dx = cy_in >>> i;
    assign dy = cx_in >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fc_q[i] <= '0;
      end else begin
        fc_q[i] <= fl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!cy_in[CX_W-1]) begin
        cx_q[i] <= cx_in + dx;
        cy_q[i] <= cy_in - dy;
        z_q[i]  <= z_in + atan_tab(i);
      end else begin
        cx_q[i] <= cx_in - dx;
        cy_q[i] <= cy_in + dy;
        z_q[i]  <= z_in - atan_tab(i);
      end
    end
  end

  // Clamp to the first quadrant, unfold by the signs, round and saturate; a zero input gives zero.
  always_comb begin
    z_c = z_q[ST-1];
    if (z_c < 0) z_c = '0;
    if (z_c > HALF_PI_Q) z_c = HALF_PI_Q;
    if (fc_q[ST-1].xneg) z_c = PI_Q - z_c;
    if (fc_q[ST-1].yneg) z_c = -z_c;
    zr_c = z_c + ROUND_Q;
    r_c  = zr_c[ANG_W-1:SHIFT];
    if (r_c > R_W'(OUT_MAX)) begin
      t_c = OUT_MAX;
    end else if (r_c < -R_W'(OUT_MAX)) begin
      t_c = -OUT_MAX;
    end else begin
      t_c = r_c[TORS_W-1:0];
    end
    if (fc_q[ST-1].zero) t_c = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= fc_q[ST-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    torsion_q <= t_c;
  end

  assign vld_o     = vld_q;
  assign torsion_o = torsion_q;

  // Every valid input reappears on vld_o after the entry, normalisation, rotation and output registers.
  `DANG_ASSERT(a_latency, clk_i, rst_ni, vld_o == $past(vld_i, LAT))
  // The normalised magnitudes fit the CORDIC input width.
  `DANG_ASSERT(a_norm_fit, clk_i, rst_ni, fn_q[NS].vld |-> ((nx_q[NS] >> NORM_BITS) == '0 && (ny_q[NS] >> NORM_BITS) == '0))
  // A result never lies outside plus or minus pi.
  `DANG_ASSERT_NEVER(a_range, clk_i, rst_ni, vld_o && (torsion_o > OUT_MAX || torsion_o < -OUT_MAX))

endmodule

// File: rtl/core/dihedral_angle_top.sv
// Top level of the dihedral angle core: bond vectors, cross and dot products, alignment.
// Depends on dang_pkg, dang_dly, dang_mul, dang_sqrt and dang_cordic.
//
// Usage: drive the twelve point coordinates (1/256 angstrom, two's complement)
// with start_i high for one cycle per transaction. busy_o is always low, so a
// transaction is taken at every rising edge at which start_i is high, one per
// cycle with no gaps needed. Each transaction yields one result on torsion_o
// (radians times 8192, -25736..25736), marked by done_o for exactly one cycle.
// The bit-serial square root of |b2|^2 sets the length of the pipeline; throughput
// is one per cycle.
// Reset clears all valid bits, so no result appears until a new transaction.
// The receiver cannot stall; results are never held back.
module dihedral_angle_top import dang_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ATAN_STEPS  = ATAN_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] p0_x_i,
  input  logic signed [COORD_WIDTH-1:0] p0_y_i,
  input  logic signed [COORD_WIDTH-1:0] p0_z_i,
  input  logic signed [COORD_WIDTH-1:0] p1_x_i,
  input  logic signed [COORD_WIDTH-1:0] p1_y_i,
  input  logic signed [COORD_WIDTH-1:0] p1_z_i,
  input  logic signed [COORD_WIDTH-1:0] p2_x_i,
  input  logic signed [COORD_WIDTH-1:0] p2_y_i,
  input  logic signed [COORD_WIDTH-1:0] p2_z_i,
  input  logic signed [COORD_WIDTH-1:0] p3_x_i,
  input  logic signed [COORD_WIDTH-1:0] p3_y_i,
  input  logic signed [COORD_WIDTH-1:0] p3_z_i,
  output logic                          done_o,
  output logic signed [TORS_W-1:0]      torsion_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned D_W     = W + 1;
  localparam int unsigned PR_W    = 2 * W + 2;
  localparam int unsigned C_W     = 2 * W + 3;
  localparam int unsigned S_W     = 2 * W + 2;
  localparam int unsigned TP_W    = D_W + C_W;
  localparam int unsigned T_W     = 3 * W + 6;
  localparam int unsigned XP_P_W  = 2 * C_W;
  localparam int unsigned XP_W    = 4 * W + 8;
  localparam int unsigned LEN_W   = (S_W + 2 * LEN_FRAC + 1) / 2;
  localparam int unsigned LEN_S_W = LEN_W + 1;
  localparam int unsigned Y_W     = LEN_S_W + T_W;
  localparam int unsigned X_W     = XP_W + LEN_FRAC;

  // Cycle at which each branch result is registered.
  localparam int unsigned T_T  = 4 + mul_lat(D_W, C_W);
  localparam int unsigned T_X  = 4 + mul_lat(C_W, C_W);
  localparam int unsigned T_S  = 3 + LEN_W;
  localparam int unsigned T_Y0 = max_u(T_T, T_S);
  localparam int unsigned T_Y  = T_Y0 + mul_lat(LEN_S_W, T_W);

  logic                  v1_q;
  logic signed [D_W-1:0] b1_q [3];
  logic signed [D_W-1:0] b2_q [3];
  logic signed [D_W-1:0] b3_q [3];

  logic signed [D_W-1:0]  b1d_q [3];
  logic signed [PR_W-1:0] pr23_q [6];
  logic signed [PR_W-1:0] pr12_q [6];
  logic signed [PR_W-1:0] sq_q   [3];

  logic signed [D_W-1:0] b1e_q  [3];
  logic signed [C_W-1:0] c23_q  [3];
  logic signed [C_W-1:0] c12_q  [3];
  logic [S_W-1:0]        s_q;

  logic signed [TP_W-1:0]   tp  [3];
  logic signed [XP_P_W-1:0] xp  [3];
  logic signed [T_W-1:0]    t_q;
  logic signed [XP_W-1:0]   xs_q;
  logic [LEN_W-1:0]         len;

  logic [T_W-1:0]         t_al;
  logic [LEN_W-1:0]       len_al;
  logic signed [X_W-1:0]  x_full;
  logic [X_W-1:0]         x_al;
  logic signed [Y_W-1:0]  y;
  logic                   v_al;

  // The pipeline never stalls, so every start is a transaction.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  // Bond vectors.
  always_ff @(posedge clk_i) begin
    b1_q[0] <= D_W'(p1_x_i) - D_W'(p0_x_i);
    b1_q[1] <= D_W'(p1_y_i) - D_W'(p0_y_i);
    b1_q[2] <= D_W'(p1_z_i) - D_W'(p0_z_i);
    b2_q[0] <= D_W'(p2_x_i) - D_W'(p1_x_i);
    b2_q[1] <= D_W'(p2_y_i) - D_W'(p1_y_i);
    b2_q[2] <= D_W'(p2_z_i) - D_W'(p1_z_i);
    b3_q[0] <= D_W'(p3_x_i) - D_W'(p2_x_i);
    b3_q[1] <= D_W'(p3_y_i) - D_W'(p2_y_i);
    b3_q[2] <= D_W'(p3_z_i) - D_W'(p2_z_i);
  end

  // Coordinate products for both cross products and for |b2|^2.
  always_ff @(posedge clk_i) begin
    pr23_q[0] <= PR_W'(b2_q[1]) * PR_W'(b3_q[2]);
    pr23_q[1] <= PR_W'(b2_q[2]) * PR_W'(b3_q[1]);
    pr23_q[2] <= PR_W'(b2_q[2]) * PR_W'(b3_q[0]);
    pr23_q[3] <= PR_W'(b2_q[0]) * PR_W'(b3_q[2]);
    pr23_q[4] <= PR_W'(b2_q[0]) * PR_W'(b3_q[1]);
    pr23_q[5] <= PR_W'(b2_q[1]) * PR_W'(b3_q[0]);
    pr12_q[0] <= PR_W'(b1_q[1]) * PR_W'(b2_q[2]);
    pr12_q[1] <= PR_W'(b1_q[2]) * PR_W'(b2_q[1]);
    pr12_q[2] <= PR_W'(b1_q[2]) * PR_W'(b2_q[0]);
    pr12_q[3] <= PR_W'(b1_q[0]) * PR_W'(b2_q[2]);
    pr12_q[4] <= PR_W'(b1_q[0]) * PR_W'(b2_q[1]);
    pr12_q[5] <= PR_W'(b1_q[1]) * PR_W'(b2_q[0]);
    for (int i = 0; i < 3; i++) begin
      sq_q[i]  <= PR_W'(b2_q[i]) * PR_W'(b2_q[i]);
      b1d_q[i] <= b1_q[i];
    end
  end

  // Cross product components and the squared length of b2.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c23_q[i] <= C_W'(pr23_q[2*i]) - C_W'(pr23_q[2*i+1]);
      c12_q[i] <= C_W'(pr12_q[2*i]) - C_W'(pr12_q[2*i+1]);
      b1e_q[i] <= b1d_q[i];
    end
    s_q <= $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);
  end

  // Wide products for the two dot products.
  for (genvar i = 0; i < 3; i++) begin : g_dot
    dang_mul #(
      .A_WIDTH(D_W),
      .B_WIDTH(C_W)
    ) u_mul_t (
      .clk_i(clk_i),
      .a_i  (b1e_q[i]),
      .b_i  (c23_q[i]),
      .p_o  (tp[i])
    );

    dang_mul #(
      .A_WIDTH(C_W),
      .B_WIDTH(C_W)
    ) u_mul_x (
      .clk_i(clk_i),
      .a_i  (c12_q[i]),
      .b_i  (c23_q[i]),
      .p_o  (xp[i])
    );
  end

  always_ff @(posedge clk_i) begin
    t_q  <= T_W'(tp[0]) + T_W'(tp[1]) + T_W'(tp[2]);
    xs_q <= XP_W'(xp[0]) + XP_W'(xp[1]) + XP_W'(xp[2]);
  end

  // Length of b2 with LEN_FRAC fraction bits.
  dang_sqrt #(
    .IN_W(S_W),
    .FRAC(LEN_FRAC)
  ) u_sqrt (
    .clk_i (clk_i),
    .s_i   (s_q),
    .root_o(len)
  );

  // Bring the triple product and the length together.
  dang_dly #(.WIDTH(T_W), .DEPTH(T_Y0 - T_T)) u_dly_t (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .d_i   (t_q),
    .q_o   (t_al)
  );

  dang_dly #(.WIDTH(LEN_W), .DEPTH(T_Y0 - T_S)) u_dly_len (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .d_i   (len),
    .q_o   (len_al)
  );

  dang_mul #(
    .A_WIDTH(LEN_S_W),
    .B_WIDTH(T_W)
  ) u_mul_y (
    .clk_i(clk_i),
    .a_i  ({1'b0, len_al}),
    .b_i  (t_al),
    .p_o  (y)
  );

  // The cosine term is scaled to match the length's fraction bits.
  assign x_full = {xs_q, {LEN_FRAC{1'b0}}};

  dang_dly #(.WIDTH(X_W), .DEPTH(T_Y - T_X)) u_dly_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .d_i   (x_full),
    .q_o   (x_al)
  );

  // Valid bits run alongside the arithmetic branches.
  dang_dly #(.WIDTH(1), .DEPTH(T_Y - 1)) u_dly_vld (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .d_i   (v1_q),
    .q_o   (v_al)
  );

  dang_cordic #(
    .IN_W (X_W),
    .STEPS(ATAN_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (v_al),
    .x_i      (x_al),
    .y_i      (y),
    .vld_o    (done_o),
    .torsion_o(torsion_o)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the dihedral angle core: directed and random point quadruples.
// Depends on dang_pkg and dihedral_angle_top; the expected torsion is computed here exactly.
`timescale 1ns / 1ps

module tb_top import dang_pkg::*;;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int signed CMAX = (1 <<< (CW - 1)) - 1;
  localparam int signed CMIN = -(1 <<< (CW - 1));
  localparam int unsigned EXP_DEPTH = 4096;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t quad_t [12];
  typedef logic signed [191:0] wide_t;
  typedef logic signed [TORS_W-1:0] tors_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic done_o;
  tors_t torsion_o;
  coord_t pt_q [12];

  // Expected results in order, written at acceptance and read at each result.
  tors_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  bit no_gaps;

  dihedral_angle_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .p0_x_i(pt_q[0]), .p0_y_i(pt_q[1]), .p0_z_i(pt_q[2]),
    .p1_x_i(pt_q[3]), .p1_y_i(pt_q[4]), .p1_z_i(pt_q[5]),
    .p2_x_i(pt_q[6]), .p2_y_i(pt_q[7]), .p2_z_i(pt_q[8]),
    .p3_x_i(pt_q[9]), .p3_y_i(pt_q[10]), .p3_z_i(pt_q[11]),
    .done_o(done_o), .torsion_o(torsion_o)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Integer square root, floor, by trying each result bit from the top.
  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  function automatic int unsigned bit_length(input wide_t v);
    for (int i = 191; i >= 0; i--) if (v[i]) return i + 1;
    return 0;
  endfunction

  // Expected torsion of one quadruple: exact products, square root, CORDIC, rounding.
  function automatic tors_t torsion_of(input quad_t q);
    wide_t b1 [3];
    wide_t b2 [3];
    wide_t b3 [3];
    wide_t c12 [3];
    wide_t c23 [3];
    wide_t t, x, y, mx, my, ss;
    logic [63:0] len;
    bit xneg, yneg;
    int unsigned n, sh;
    longint cx, cy, z, dx, dy, r;
    for (int i = 0; i < 3; i++) begin
      b1[i] = wide_t'(q[3+i]) - wide_t'(q[i]);
      b2[i] = wide_t'(q[6+i]) - wide_t'(q[3+i]);
      b3[i] = wide_t'(q[9+i]) - wide_t'(q[6+i]);
    end
    c23[0] = b2[1] * b3[2] - b2[2] * b3[1];
    c23[1] = b2[2] * b3[0] - b2[0] * b3[2];
    c23[2] = b2[0] * b3[1] - b2[1] * b3[0];
    c12[0] = b1[1] * b2[2] - b1[2] * b2[1];
    c12[1] = b1[2] * b2[0] - b1[0] * b2[2];
    c12[2] = b1[0] * b2[1] - b1[1] * b2[0];
    t = b1[0] * c23[0] + b1[1] * c23[1] + b1[2] * c23[2];
    x = (c12[0] * c23[0] + c12[1] * c23[1] + c12[2] * c23[2]) <<< LEN_FRAC;
    ss = (b2[0] * b2[0] + b2[1] * b2[1] + b2[2] * b2[2]) <<< (2 * LEN_FRAC);
    len = isqrt128(ss[127:0]);
    y = wide_t'({128'd0, len}) * t;
    if (x == 0 && y == 0) return '0;
    xneg = x < 0;
    yneg = y < 0;
    mx = xneg ? -x : x;
    my = yneg ? -y : y;
    n = bit_length(mx);
    if (bit_length(my) > n) n = bit_length(my);
    sh = (n > NORM_BITS) ? n - NORM_BITS : 0;
    mx = mx >> sh;
    my = my >> sh;
    cx = longint'({32'd0, mx[31:0]});
    cy = longint'({32'd0, my[31:0]});
    z = 0;
    // First-quadrant vectoring.
    for (int i = 0; i < COORD_WIDTH_DEF * 0 + ATAN_STEPS_DEF && i < TAB_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += longint'(atan_tab(i));
      end else begin
        cx -= dx; cy += dy; z -= longint'(atan_tab(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q)) z = longint'(HALF_PI_Q);
    if (xneg) z = longint'(PI_Q) - z;
    if (yneg) z = -z;
    r = (z + (64'sd1 <<< (ANG_FRAC - OUT_FRAC - 1))) >>> (ANG_FRAC - OUT_FRAC);
    if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
    if (r < -longint'(OUT_MAX)) r = -longint'(OUT_MAX);
    return tors_t'(r);
  endfunction

  // Drives one transaction and holds it until accepted, then may leave a random gap (never with no_gaps set).
  task automatic send_quad(input quad_t q);
    int unsigned gap, pick;
    for (int i = 0; i < 12; i++) pt_q[i] <= q[i];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    exp_mem[exp_wr % EXP_DEPTH] = torsion_of(q);
    exp_wr++;
    n_sent++;
    pick = $urandom_range(99);
    if (no_gaps || pick < 65) gap = 0;
    else if (pick < 95) gap = $urandom_range(3, 1);
    else gap = $urandom_range(80, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near(input coord_t base, input int unsigned span);
    return coord_t'(int'(base) + $signed($urandom_range(2 * span)) - int'(span));
  endfunction

  // Builds a quadruple from four points given as three coordinates each.
  function automatic quad_t make_quad(input int a [12]);
    quad_t q;
    for (int i = 0; i < 12; i++) q[i] = coord_t'(a[i]);
    return q;
  endfunction

  // Extremes of the fields and the named special cases.
  task automatic test_directed();
    quad_t q;
    send_quad(make_quad('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    // Cis, trans, plus and minus ninety degrees.
    send_quad(make_quad('{256, 256, 0, 0, 0, 0, 0, 256, 0, 256, 256, 0}));
    send_quad(make_quad('{256, 0, 0, 0, 0, 0, 0, 256, 0, -256, 256, 0}));
    send_quad(make_quad('{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, 256}));
    send_quad(make_quad('{256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 256, -256}));
    // Collinear points and repeated points give degenerate geometry.
    send_quad(make_quad('{0, 0, 0, 100, 100, 100, 200, 200, 200, 300, 300, 300}));
    send_quad(make_quad('{5, 6, 7, 5, 6, 7, 9, 1, 3, 2, 8, 4}));
    send_quad(make_quad('{1, 2, 3, 4, 5, 6, 4, 5, 6, 7, 9, 1}));
    // Full-scale corners of the coordinate range.
    send_quad(make_quad('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN,
                          CMAX, CMIN, CMAX}));
    send_quad(make_quad('{CMAX, CMIN, 0, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX,
                          CMIN, CMIN, CMAX}));
    send_quad(make_quad('{CMAX, 0, 0, CMIN, 0, 0, CMIN, CMAX, 0, CMIN, CMIN, CMAX}));
    send_quad(make_quad('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                          CMIN, CMIN, CMIN}));
    send_quad(make_quad('{CMAX, CMAX, CMAX, 0, 0, 0, CMIN, CMIN, CMIN, CMAX, CMIN, 0}));
    send_quad(make_quad('{-1, -1, -1, 0, 0, 0, 1, 0, 0, 1, 1, 1}));
    send_quad(make_quad('{0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, -1}));
    for (int i = 0; i < 12; i++) q[i] = (i % 2) ? coord_t'(CMAX) : coord_t'(CMIN);
    send_quad(q);
  endtask

  // Chain-like quadruples with short bonds around a random origin.
  task automatic test_random_chains(input int unsigned count, input bit burst);
    quad_t q;
    int unsigned span;
    no_gaps = burst;
    for (int k = 0; k < count; k++) begin
      span = ($urandom_range(9) == 0) ? 40000 : $urandom_range(1024, 1);
      q[0] = rand_coord(); q[1] = rand_coord(); q[2] = rand_coord();
      for (int i = 3; i < 12; i++) q[i] = near(q[i-3], span);
      send_quad(q);
    end
    no_gaps = 1'b0;
  endtask

  // Arbitrary coordinates over the full field width.
  task automatic test_random_full(input int unsigned count);
    quad_t q;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 12; i++) q[i] = rand_coord();
      send_quad(q);
    end
  endtask

  // Planar, collinear and coincident quadruples where one or both terms vanish.
  task automatic test_degenerate(input int unsigned count);
    quad_t q;
    int unsigned kind;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 12; i++) q[i] = near(coord_t'(0), 3000);
      kind = $urandom_range(2);
      if (kind == 0) begin
        for (int i = 0; i < 4; i++) q[3*i+2] = q[2];
      end else if (kind == 1) begin
        for (int i = 0; i < 3; i++) q[6+i] = q[3+i];
      end else begin
        for (int i = 3; i < 12; i++) q[i] = coord_t'(int'(q[i%3]) * (i / 3 + 1));
      end
      send_quad(q);
    end
  endtask

  // Compares each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (exp_rd == exp_wr) begin
        $error("torsion: result with no transaction outstanding, actual %0d", torsion_o);
        n_errors++;
      end else begin
        if (torsion_o !== exp_mem[exp_rd % EXP_DEPTH]) begin
          $error("torsion: expected %0d, actual %0d", exp_mem[exp_rd % EXP_DEPTH],
                 torsion_o);
          n_errors++;
        end
        exp_rd++;
        n_checked++;
      end
    end
  end

  // Safety net against a hung run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    exp_wr = 0;
    exp_rd = 0;
    no_gaps = 1'b0;
    start_i = 1'b0;
    for (int i = 0; i < 12; i++) pt_q[i] = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_chains(600, 1'b0);
    test_random_chains(200, 1'b1);
    test_random_full(450);
    test_degenerate(280);
    start_i <= 1'b0;

    while (exp_rd != exp_wr) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d point quadruples (directed, chains, full range, degenerate);",
             n_sent);
    $display("checked %0d torsion results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
